FILE: rtl/aoc_pkg.sv
// ----------------------------------------------------------------------------
// Audio output conditioner package
// Widths, register indexes, filter mode codes and fixed-point constants
// shared by the conditioner RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package aoc_pkg;

  // Field widths.
  localparam int unsigned SUM_W   = 32;  // mixed sum input
  localparam int unsigned SMP_W   = 24;  // sample after the shift by 8
  localparam int unsigned ACC_W   = 48;  // high-pass accumulator
  localparam int unsigned FRAC_W  = 16;  // accumulator fraction bits
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned PCM_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CIDX_W  = 1;
  localparam int unsigned CDAT_W  = 16;

  // Low-pass sums hold up to four samples.
  localparam int unsigned LPS_W   = SMP_W + 2;

  // Truncating divide by three through a reciprocal: q = (m * DIV3_MUL) >> DIV3_SHIFT.
  // Exact for all magnitudes below 2**DIV3_SHIFT, which covers three full-scale samples.
  localparam int unsigned DIV3_SHIFT = 27;
  localparam int unsigned DIV3_W     = 26;
  localparam logic [DIV3_W-1:0] DIV3_MUL = 26'd44739243;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_FILTER_MODE = 1'b0;
  localparam logic [CIDX_W-1:0] REG_HPF_COEFF   = 1'b1;

  // Low-pass filter mode codes; the unused codes behave as no filtering.
  localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TWO_TAP  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_THREE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FOUR_TAP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED = 3'd4;

  localparam logic [COEF_W-1:0] HPF_COEFF_RST = 16'd373;

  // Saturation limits.
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sh8000;

endpackage : aoc_pkg

`default_nettype wire

FILE: rtl/audio_output_conditioner_unit.sv
// ----------------------------------------------------------------------------
// Audio output conditioner
// Moving-average low-pass, DC-blocking high-pass and 16/8-bit output format.
// ----------------------------------------------------------------------------
// Usage:
//   One mixed sum enters per transaction on the in_ channel (valid/ready) and
//   one conditioned sample leaves per transaction on the out_ channel, as a
//   signed 16-bit value and as an offset-binary byte.
//   The block is a two-stage pipeline. Stage one shifts the sum down by 8 and
//   runs the selected moving average, updating the low-pass history in the
//   same cycle. Stage two runs the high-pass accumulator loop and saturates.
//   A sample accepted at a clock edge is registered in stage one (y_r) and
//   then in the output register (pcm_r); a stall holds it in stage one. One
//   item is accepted every cycle while the output does not stall; the
//   accumulator feedback loop, closed through acc_r alone, is what allows this rate.
//   When the receiver stalls, both stages hold and in_ready drops as long as
//   the output register is full and out_ready is low.
//   Reset (rst_n low at a clock edge) empties the pipeline, clears the
//   history and the accumulator, selects no filtering and loads the default
//   high-pass coefficient. Configuration writes are registered; the user must
//   make them only while the pipeline is empty, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_output_conditioner_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [aoc_pkg::SUM_W-1:0]     in_mixed_sum,
  // Result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [aoc_pkg::PCM_W-1:0]     out_pcm16,
  output logic        [aoc_pkg::BYTE_W-1:0]    out_pcm8,
  // Configuration port
  input  wire                                  cfg_wr_en,
  input  wire         [aoc_pkg::CIDX_W-1:0]    cfg_index,
  input  wire         [aoc_pkg::CDAT_W-1:0]    cfg_data
);

  localparam int unsigned SMP_W  = aoc_pkg::SMP_W;
  localparam int unsigned LPS_W  = aoc_pkg::LPS_W;
  localparam int unsigned ACC_W  = aoc_pkg::ACC_W;
  localparam int unsigned FRAC_W = aoc_pkg::FRAC_W;
  localparam int unsigned COEF_W = aoc_pkg::COEF_W;
  localparam int unsigned DIV3_W = aoc_pkg::DIV3_W;
  localparam int unsigned PROD_W = COEF_W + 1 + ACC_W;

  // Configuration registers.
  logic [aoc_pkg::MODE_W-1:0] mode_r;
  logic [COEF_W-1:0]          coeff_r;

  // Pipeline control.
  logic advance;      // both stages move this cycle
  logic in_fire;
  logic s1_valid_r;
  logic out_valid_r;

  // Stage one state.
  logic signed [SMP_W-1:0] hist_r   [3];
  logic signed [SMP_W-1:0] hist_nxt [3];
  logic signed [SMP_W-1:0] y_nxt;
  logic signed [SMP_W-1:0] y_r;

  // Stage two state.
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [aoc_pkg::PCM_W-1:0] pcm_nxt;
  logic signed [aoc_pkg::PCM_W-1:0] pcm_r;

  // The output register separates the two sides: everything moves whenever
  // the output register is empty or being taken.
  assign advance   = out_ready || !out_valid_r;
  assign in_ready  = advance;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_pcm16 = pcm_r;
  assign out_pcm8  = {~pcm_r[aoc_pkg::PCM_W-1], pcm_r[aoc_pkg::PCM_W-2:aoc_pkg::BYTE_W]};

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= aoc_pkg::MODE_NONE;
      coeff_r <= aoc_pkg::HPF_COEFF_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        aoc_pkg::REG_FILTER_MODE: mode_r  <= cfg_data[aoc_pkg::MODE_W-1:0];
        aoc_pkg::REG_HPF_COEFF:   coeff_r <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage one: shift by 8 (floor) and moving-average low-pass
  // --------------------------------------------------------------------------
  logic signed [SMP_W-1:0] x;
  logic signed [LPS_W-1:0] sum2, sum3, sum4, sumw;
  logic signed [LPS_W-1:0] half, quart, quartw;
  logic        [DIV3_W-1:0] mag3;
  logic        [DIV3_W+DIV3_W-1:0] prod3;
  logic        [SMP_W-1:0] q3;
  logic signed [SMP_W-1:0] third;

  // The arithmetic shift right by 8 is just the upper bits of the sum.
  assign x = in_mixed_sum[aoc_pkg::SUM_W-1:aoc_pkg::SUM_W-SMP_W];

  always_comb begin
    sum2 = LPS_W'(hist_r[0]) + LPS_W'(x);
    sum3 = LPS_W'(hist_r[1]) + LPS_W'(hist_r[0]) + LPS_W'(x);
    sum4 = LPS_W'(hist_r[2]) + LPS_W'(hist_r[1]) + LPS_W'(hist_r[0]) + LPS_W'(x);
    sumw = LPS_W'(hist_r[1]) + (LPS_W'(hist_r[0]) <<< 1) + LPS_W'(x);

    // Division toward zero: bias negative values before the shift.
    half   = (sum2 + (sum2[LPS_W-1] ? LPS_W'(1) : LPS_W'(0))) >>> 1;
    quart  = (sum4 + (sum4[LPS_W-1] ? LPS_W'(3) : LPS_W'(0))) >>> 2;
    quartw = (sumw + (sumw[LPS_W-1] ? LPS_W'(3) : LPS_W'(0))) >>> 2;

    // Divide the magnitude by three with the reciprocal, then restore sign.
    mag3  = sum3[LPS_W-1] ? DIV3_W'(-sum3) : DIV3_W'(sum3);
    prod3 = mag3 * aoc_pkg::DIV3_MUL;
    q3    = prod3[aoc_pkg::DIV3_SHIFT +: SMP_W];
    third = sum3[LPS_W-1] ? -$signed(q3) : $signed(q3);

    hist_nxt = hist_r;
    case (mode_r)
      aoc_pkg::MODE_TWO_TAP: begin
        y_nxt       = half[SMP_W-1:0];
        hist_nxt[0] = y_nxt;
      end
      aoc_pkg::MODE_THREE: begin
        y_nxt       = third;
        hist_nxt[1] = hist_r[0];
        hist_nxt[0] = y_nxt;
      end
      aoc_pkg::MODE_FOUR_TAP: begin
        y_nxt       = quart[SMP_W-1:0];
        hist_nxt[2] = hist_r[1];
        hist_nxt[1] = hist_r[0];
        hist_nxt[0] = y_nxt;
      end
      aoc_pkg::MODE_WEIGHTED: begin
        y_nxt       = quartw[SMP_W-1:0];
        hist_nxt[1] = hist_r[0];
        hist_nxt[0] = y_nxt;
      end
      default: begin
        y_nxt = x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      hist_r[0]  <= '0;
      hist_r[1]  <= '0;
      hist_r[2]  <= '0;
    end else begin
      if (advance) begin
        s1_valid_r <= in_fire;
      end
      if (in_fire) begin
        hist_r <= hist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      y_r <= y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage two: DC-blocking high-pass and saturation
  // --------------------------------------------------------------------------
  logic signed [ACC_W:0]    diff;
  logic signed [ACC_W-1:0]  d;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W:0]    step;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W:0]    d_bias;
  logic signed [ACC_W-FRAC_W:0] o;

  always_comb begin
    diff = ((ACC_W+1)'(y_r) <<< FRAC_W) - (ACC_W+1)'(acc_r);
    if (diff[ACC_W] != diff[ACC_W-1]) begin
      d = diff[ACC_W] ? aoc_pkg::ACC_MIN : aoc_pkg::ACC_MAX;
    end else begin
      d = diff[ACC_W-1:0];
    end

    // Coefficient times difference, reduced by flooring the fraction bits.
    prod    = PROD_W'($signed({1'b0, coeff_r})) * PROD_W'(d);
    step    = prod[FRAC_W +: (ACC_W+1)];
    acc_sum = (ACC_W+1)'(acc_r) + step;
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? aoc_pkg::ACC_MIN : aoc_pkg::ACC_MAX;
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end

    // Output sample: difference truncated toward zero, then saturated.
    d_bias = (ACC_W+1)'(d) + (d[ACC_W-1] ? (ACC_W+1)'({FRAC_W{1'b1}}) : '0);
    o      = d_bias[ACC_W:FRAC_W];
    if (o > (ACC_W-FRAC_W+1)'(aoc_pkg::PCM_MAX)) begin
      pcm_nxt = aoc_pkg::PCM_MAX;
    end else if (o < (ACC_W-FRAC_W+1)'(aoc_pkg::PCM_MIN)) begin
      pcm_nxt = aoc_pkg::PCM_MIN;
    end else begin
      pcm_nxt = o[aoc_pkg::PCM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      pcm_r <= pcm_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // With no filtering selected, an accepted sample leaves the history alone.
  a_hist_hold_no_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_r != aoc_pkg::MODE_TWO_TAP && mode_r != aoc_pkg::MODE_THREE &&
     mode_r != aoc_pkg::MODE_FOUR_TAP && mode_r != aoc_pkg::MODE_WEIGHTED)
    |=> (hist_r[0] == $past(hist_r[0]) && hist_r[1] == $past(hist_r[1]) &&
         hist_r[2] == $past(hist_r[2])))
    else $error("low-pass history changed with filtering off");

  // The accumulator only moves when a sample passes from stage one to the output.
  a_acc_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && s1_valid_r) |=> $stable(acc_r))
    else $error("high-pass accumulator changed without a sample");

  // A sample waiting in stage one is never dropped during a stall.
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("stage one sample lost during stall");

  // Every accepted sample reaches the output register when stage one is not stalled.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire ##1 advance) |=> out_valid_r)
    else $error("accepted sample did not reach the output register");

endmodule : audio_output_conditioner_unit

`default_nettype wire
